FILE: design/eot_pkg.sv
// ----------------------------------------------------------------------------
// Encoder odometry tracker package
// Shared types, widths and register codes for the odometry pipeline.
// ----------------------------------------------------------------------------
package eot_pkg;

    // Working width of the wrap-corrected delta. It must hold
    // +-(2^32 + period), so two bits more than the 33-bit period.
    localparam int DW        = 35;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 33;
    localparam int TDATA_W   = 256;
    localparam int TUSER_W   = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VSCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DSCALE     = 3'd4;

    localparam logic [32:0] PERIOD_RST     = 33'h0_0001_0000;
    localparam logic [31:0] STEP_LIMIT_RST = 32'hFFFF_FFFF;

    // Saturation bounds on the delta magnitude
    localparam logic [DW-1:0] AD_POS_MAX = DW'(64'h0000_0000_7FFF_FFFF);
    localparam logic [DW-1:0] AD_NEG_MAX = DW'(64'h0000_0000_8000_0000);
    localparam logic [DW-1:0] AD_U32_MAX = DW'(64'h0000_0000_FFFF_FFFF);

    localparam logic [63:0] SPD_CAP_POS  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SPD_CAP_NEG  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] DIST_CAP_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DIST_CAP_NEG = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [32:0] period;
        logic [31:0] step_limit;
        logic        invert;
        logic [31:0] vscale;
        logic [31:0] dscale;
    } cfg_t;

    // Delta front end to accumulator
    typedef struct packed {
        logic                 primed;
        logic                 fault;
        logic signed [DW-1:0] d;
        logic [DW-1:0]        ad;
        logic                 fd_neg;
    } dlt_t;

    // Accumulator to scaling back end
    typedef struct packed {
        logic        primed;
        logic        fault;
        logic [31:0] dticks;
        logic [31:0] dmag;
        logic [63:0] total;
        logic [DW-1:0] spd_mag;
        logic        spd_neg;
        logic [63:0] dist_mag;
        logic        dist_neg;
        logic [31:0] fault_total;
    } acc_t;

    typedef struct packed {
        logic        primed;
        logic        fault;
        logic [31:0] dticks;
        logic [31:0] dmag;
        logic [63:0] total;
        logic [31:0] speed;
        logic [63:0] distance;
        logic [31:0] fault_total;
    } res_t;

endpackage

FILE: design/eot_delta.sv
// ----------------------------------------------------------------------------
// Encoder odometry delta front end
// Three stages: raw difference, wrap fold plus limit clamp, magnitude check.
// ----------------------------------------------------------------------------
module eot_delta (
    input  logic          clk,
    input  logic          rst_n,
    input  eot_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [31:0]   in_count,
    output logic          out_valid,
    input  logic          out_ready,
    output eot_pkg::dlt_t out_item
);
    import eot_pkg::*;

    typedef struct packed {
        logic                 primed;
        logic signed [DW-1:0] d;
    } st0_t;

    typedef struct packed {
        logic                 primed;
        logic signed [DW-1:0] d;
        logic [31:0]          limit;
    } st1_t;

    logic [31:0] last_count_reg;
    logic        have_sample_reg;
    logic        v0_reg, v1_reg, v2_reg;
    logic        rdy0, rdy1, rdy2;
    st0_t        s0_reg, s0_next;
    st1_t        s1_reg, s1_next;
    dlt_t        s2_reg, s2_next;

    logic signed [DW-1:0] p_s, h_s, d_sub, d_add;
    logic [31:0]          h_m1;
    logic                 d_neg;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    // Stage 0: raw difference against the previous reading
    always_comb
    begin
        s0_next.primed = !have_sample_reg;
        s0_next.d      = signed'({3'b000, in_count}) - signed'({3'b000, last_count_reg});
    end

    // Stage 1: fold into +-period/2 and clamp the limit
    always_comb
    begin
        p_s   = signed'({2'b00, cfg.period});
        h_s   = signed'({3'b000, cfg.period[32:1]});
        d_sub = s0_reg.d - p_s;
        d_add = s0_reg.d + p_s;
        h_m1  = cfg.period[32:1] - 32'd1;

        s1_next.primed = s0_reg.primed;
        if (cfg.period <= 33'd1)
        begin
            s1_next.d = '0;
        end
        else if (s0_reg.d > h_s)
        begin
            s1_next.d = d_sub;
        end
        else if (s0_reg.d < -h_s)
        begin
            s1_next.d = d_add;
        end
        else
        begin
            s1_next.d = s0_reg.d;
        end

        if (cfg.period > 33'd2 && cfg.step_limit > h_m1)
        begin
            s1_next.limit = h_m1;
        end
        else
        begin
            s1_next.limit = cfg.step_limit;
        end
    end

    // Stage 2: magnitude and plausibility check
    always_comb
    begin
        d_neg          = s1_reg.d[DW-1];
        s2_next.primed = s1_reg.primed;
        s2_next.d      = s1_reg.d;
        s2_next.ad     = d_neg ? DW'(-s1_reg.d) : DW'(s1_reg.d);
        s2_next.fault  = !s1_reg.primed && (s2_next.ad > {{(DW-32){1'b0}}, s1_reg.limit});
        s2_next.fd_neg = (d_neg ^ cfg.invert) && (s1_reg.d != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg  <= '0;
            have_sample_reg <= 1'b0;
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
        end
        else
        begin
            if (in_valid && rdy0)
            begin
                last_count_reg  <= in_count;
                have_sample_reg <= 1'b1;
            end
            v0_reg <= (in_valid && rdy0) || (v0_reg && !rdy1);
            v1_reg <= (v0_reg && rdy1) || (v1_reg && !rdy2);
            v2_reg <= (v1_reg && rdy2) || (v2_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy0)
        begin
            s0_reg <= s0_next;
        end
        if (v0_reg && rdy1)
        begin
            s1_reg <= s1_next;
        end
        if (v1_reg && rdy2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = s2_reg;

endmodule

FILE: design/eot_accum.sv
// ----------------------------------------------------------------------------
// Encoder odometry accumulator
// Tick total, fault counter and delta saturation, one stage.
// ----------------------------------------------------------------------------
module eot_accum (
    input  logic          clk,
    input  logic          rst_n,
    input  eot_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  eot_pkg::dlt_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output eot_pkg::acc_t out_item
);
    import eot_pkg::*;

    // Keep the total and its negation side by side so no negate follows the add
    logic [63:0] tick_total_reg, tick_total_next;
    logic [63:0] neg_total_reg, neg_total_next;
    logic [31:0] fault_count_reg, fault_count_next;
    logic        v_reg;
    logic        rdy, load, take;
    logic [63:0] d_ext, tot, ntot;
    acc_t        a_reg, a_next;

    assign rdy      = !v_reg || out_ready;
    assign load     = in_valid && rdy;
    assign in_ready = rdy;

    always_comb
    begin
        take  = !in_item.primed && !in_item.fault;
        d_ext = take ? {{(64-DW){in_item.d[DW-1]}}, in_item.d} : 64'd0;

        tick_total_next  = tick_total_reg + d_ext;
        neg_total_next   = neg_total_reg - d_ext;
        fault_count_next = fault_count_reg;
        if (in_item.fault && fault_count_reg != 32'hFFFF_FFFF)
        begin
            fault_count_next = fault_count_reg + 32'd1;
        end

        tot  = cfg.invert ? neg_total_next : tick_total_next;
        ntot = cfg.invert ? tick_total_next : neg_total_next;

        a_next.primed      = in_item.primed;
        a_next.fault       = in_item.fault;
        a_next.total       = tot;
        a_next.dist_neg    = tot[63];
        a_next.dist_mag    = tot[63] ? ntot : tot;
        a_next.fault_total = fault_count_next;
        a_next.spd_neg     = take && in_item.fd_neg;
        a_next.spd_mag     = take ? in_item.ad : '0;

        if (!take)
        begin
            a_next.dticks = '0;
        end
        else if (in_item.fd_neg)
        begin
            a_next.dticks = (in_item.ad > AD_NEG_MAX) ? 32'h8000_0000 :
                            32'd0 - in_item.ad[31:0];
        end
        else
        begin
            a_next.dticks = (in_item.ad > AD_POS_MAX) ? 32'h7FFF_FFFF : in_item.ad[31:0];
        end

        if (!take)
        begin
            a_next.dmag = '0;
        end
        else
        begin
            a_next.dmag = (in_item.ad > AD_U32_MAX) ? 32'hFFFF_FFFF : in_item.ad[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_total_reg  <= '0;
            neg_total_reg   <= '0;
            fault_count_reg <= '0;
            v_reg           <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                tick_total_reg  <= tick_total_next;
                neg_total_reg   <= neg_total_next;
                fault_count_reg <= fault_count_next;
            end
            v_reg <= load || (v_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg <= a_next;
        end
    end

    assign out_valid = v_reg;
    assign out_item  = a_reg;

endmodule

FILE: design/eot_scale.sv
// ----------------------------------------------------------------------------
// Encoder odometry scaling
// Speed and distance products with saturation: multiply, combine, cap.
// ----------------------------------------------------------------------------
module eot_scale (
    input  logic          clk,
    input  logic          rst_n,
    input  eot_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  eot_pkg::acc_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output eot_pkg::res_t out_item
);
    import eot_pkg::*;

    typedef struct packed {
        logic        primed;
        logic        fault;
        logic [31:0] dticks;
        logic [31:0] dmag;
        logic [63:0] total;
        logic [31:0] fault_total;
    } pass_t;

    typedef struct packed {
        pass_t       p;
        logic        s_neg;
        logic        s_big;
        logic [63:0] s_prod;
        logic        d_neg;
        logic [63:0] d_lo;
        logic [63:0] d_hi;
    } mul_t;

    typedef struct packed {
        pass_t       p;
        logic        s_neg;
        logic [31:0] s_mag;
        logic        d_neg;
        logic        d_ovf;
        logic [63:0] d_sum;
    } sum_t;

    logic  v0_reg, v1_reg, v2_reg;
    logic  rdy0, rdy1, rdy2;
    mul_t  m_reg, m_next;
    sum_t  c_reg, c_next;
    res_t  r_reg, r_next;
    logic [63:0] s_cap, d_cap, d_mag;
    logic [64:0] d_sum_w;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    // Stage 0: 32x32 partial products
    always_comb
    begin
        m_next.p.primed      = in_item.primed;
        m_next.p.fault       = in_item.fault;
        m_next.p.dticks      = in_item.dticks;
        m_next.p.dmag        = in_item.dmag;
        m_next.p.total       = in_item.total;
        m_next.p.fault_total = in_item.fault_total;
        m_next.s_neg  = in_item.spd_neg;
        m_next.s_big  = (in_item.spd_mag[DW-1:32] != '0) && (cfg.vscale != '0);
        m_next.s_prod = {32'd0, in_item.spd_mag[31:0]} * {32'd0, cfg.vscale};
        m_next.d_neg  = in_item.dist_neg;
        m_next.d_lo   = {32'd0, in_item.dist_mag[31:0]} * {32'd0, cfg.dscale};
        m_next.d_hi   = {32'd0, in_item.dist_mag[63:32]} * {32'd0, cfg.dscale};
    end

    // Stage 1: cap the speed magnitude, join the distance halves
    always_comb
    begin
        s_cap   = m_reg.s_neg ? SPD_CAP_NEG : SPD_CAP_POS;
        d_sum_w = {1'b0, m_reg.d_hi[31:0], 32'd0} + {1'b0, m_reg.d_lo};

        c_next.p     = m_reg.p;
        c_next.s_neg = m_reg.s_neg;
        c_next.s_mag = (m_reg.s_big || m_reg.s_prod > s_cap) ? s_cap[31:0] :
                       m_reg.s_prod[31:0];
        c_next.d_neg = m_reg.d_neg;
        c_next.d_ovf = (m_reg.d_hi[63:32] != '0) || d_sum_w[64];
        c_next.d_sum = d_sum_w[63:0];
    end

    // Stage 2: cap the distance, apply signs
    always_comb
    begin
        d_cap = c_reg.d_neg ? DIST_CAP_NEG : DIST_CAP_POS;
        d_mag = (c_reg.d_ovf || c_reg.d_sum > d_cap) ? d_cap : c_reg.d_sum;

        r_next.primed      = c_reg.p.primed;
        r_next.fault       = c_reg.p.fault;
        r_next.dticks      = c_reg.p.dticks;
        r_next.dmag        = c_reg.p.dmag;
        r_next.total       = c_reg.p.total;
        r_next.fault_total = c_reg.p.fault_total;
        r_next.speed       = c_reg.s_neg ? 32'd0 - c_reg.s_mag : c_reg.s_mag;
        r_next.distance    = c_reg.d_neg ? 64'd0 - d_mag : d_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= (in_valid && rdy0) || (v0_reg && !rdy1);
            v1_reg <= (v0_reg && rdy1) || (v1_reg && !rdy2);
            v2_reg <= (v1_reg && rdy2) || (v2_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy0)
        begin
            m_reg <= m_next;
        end
        if (v0_reg && rdy1)
        begin
            c_reg <= c_next;
        end
        if (v1_reg && rdy2)
        begin
            r_reg <= r_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = r_reg;

endmodule

FILE: design/encoder_odometry_tracker_unit.sv
// ----------------------------------------------------------------------------
// Encoder odometry tracker
// Wrap-corrected encoder deltas, tick total, fault count, speed and distance.
// ----------------------------------------------------------------------------
// Usage:
//   Send one raw counter reading per transfer on the s_axis channel. Each
//   reading yields exactly one result on m_axis, in order. The first reading
//   after reset only primes the stored count (tuser primed bit set).
//   Configuration writes go through cfg_valid/cfg_index/cfg_data; cfg_ready
//   is always high. Write registers only while no sample is in flight.
// Pipeline and throughput:
//   Seven register stages across the delta front end, accumulator and
//   scaling. One reading per cycle is sustained while m_axis_tready is high;
//   the loops are the stored count and the tick total and fault count updates.
// Reset:
//   rst_n clears the pipeline, the stored count, the total and the fault
//   count, and loads the register defaults (period 65536, no limit).
// Stall:
//   When m_axis_tready is low the result holds; the pipeline keeps taking
//   readings until every stage is full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module encoder_odometry_tracker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // counter_value [31:0]
    input  logic [31:0]                   s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // delta_ticks [31:0], delta_magnitude [63:32], total_ticks [127:64],
    // speed [159:128], distance [223:160], fault_total [255:224]
    output logic [eot_pkg::TDATA_W-1:0]   m_axis_tdata,
    // primed [0], fault [1]
    output logic [eot_pkg::TUSER_W-1:0]   m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [eot_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eot_pkg::CFG_DW-1:0]    cfg_data
);
    import eot_pkg::*;

    cfg_t  cfg_reg;
    logic  d_valid, d_ready, a_valid, a_ready;
    dlt_t  d_item;
    acc_t  a_item;
    res_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period     <= PERIOD_RST;
            cfg_reg.step_limit <= STEP_LIMIT_RST;
            cfg_reg.invert     <= 1'b0;
            cfg_reg.vscale     <= '0;
            cfg_reg.dscale     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PERIOD:     cfg_reg.period     <= cfg_data;
                REG_STEP_LIMIT: cfg_reg.step_limit <= cfg_data[31:0];
                REG_INVERT:     cfg_reg.invert     <= cfg_data[0];
                REG_VSCALE:     cfg_reg.vscale     <= cfg_data[31:0];
                REG_DSCALE:     cfg_reg.dscale     <= cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    eot_delta u_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_count  (s_axis_tdata),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_item  (d_item)
    );

    eot_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_item   (d_item),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_item  (a_item)
    );

    eot_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_item   (a_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (res)
    );

    assign m_axis_tdata = {res.fault_total, res.distance, res.speed,
                           res.total, res.dmag, res.dticks};
    assign m_axis_tuser = {res.fault, res.primed};

`ifndef SYNTHESIS
    // A primed or rejected sample carries no motion
    a_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]) |->
            m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[159:128] == 32'd0)
        else $error("motion reported on primed or faulted sample");

    // Signed and absolute delta agree on zero
    a_delta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:0] == 32'd0) == (m_axis_tdata[63:32] == 32'd0))
        else $error("delta and magnitude disagree");

    // A rejected sample is always counted
    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[255:224] != 32'd0)
        else $error("fault without fault count");

    // An empty output register means the input side is open
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
`endif

endmodule
